FILE: rtl/rsrc_pkg.sv
// Shared types, codes and state update functions of the roller shutter relay controller.
package rsrc_pkg;

	localparam int unsigned REV_GAP_MS = 200;
	localparam int unsigned MS_PER_S   = 1000;
	localparam int unsigned ADDR_W     = 4;

	typedef enum logic [3:0] {
		OP_TICK       = 4'd0,
		OP_UP         = 4'd1,
		OP_DOWN       = 4'd2,
		OP_TOGGLE     = 4'd3,
		OP_STOP       = 4'd4,
		OP_IMP_UP     = 4'd5,
		OP_IMP_DOWN   = 4'd6,
		OP_SET_OPEN   = 4'd7,
		OP_SET_CLOSED = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		REG_TRAVEL    = 2'd0,
		REG_PULSE     = 2'd1,
		REG_PAIR_STOP = 2'd2
	} reg_idx_t;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	localparam logic [2:0] CMD_STOP     = 3'd0;
	localparam logic [2:0] CMD_IMP_UP   = 3'd3;
	localparam logic [2:0] CMD_IMP_DOWN = 3'd4;
	localparam logic [2:0] CMD_NONE     = 3'd5;

	typedef struct packed {
		logic [23:0] travel_ms;
		logic [19:0] pulse_ms;
		logic        pair_stop;
		logic [19:0] rev_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  motion;
		logic        prev_dir;
		logic        open_flag;
		logic [2:0]  cmd;
		logic        up_lvl;
		logic        dn_lvl;
		logic [23:0] travel_left;
		logic [19:0] pulse_left;
		logic [20:0] stop_left;
		logic [19:0] rev_left;
		logic [1:0]  rev_target;
		logic        imp_pending;
		logic [19:0] imp_len;
	} st_t;

	typedef struct packed {
		logic       relay_up;
		logic       relay_down;
		logic [1:0] direction;
		logic       position_open;
		logic [2:0] last_command;
		logic       travel_done;
	} res_t;

	localparam st_t ST_RESET = '{
		motion:      DIR_STOP,
		prev_dir:    1'b0,
		open_flag:   1'b1,
		cmd:         CMD_NONE,
		up_lvl:      1'b0,
		dn_lvl:      1'b0,
		travel_left: '0,
		pulse_left:  '0,
		stop_left:   '0,
		rev_left:    '0,
		rev_target:  DIR_STOP,
		imp_pending: 1'b0,
		imp_len:     '0
	};

	// Stop the shutter; in pulse mode the stopping relays are pulsed.
	function automatic st_t halt_motion(input st_t s, input cfg_t c);
		st_t r;
		r = s;
		r.cmd = CMD_STOP;
		if (s.motion != DIR_STOP) begin
			if (c.pulse_ms != '0) begin
				if (c.pair_stop) begin
					r.up_lvl = 1'b1;
					r.dn_lvl = 1'b1;
				end else if (s.motion == DIR_UP) begin
					r.up_lvl = 1'b1;
				end else begin
					r.dn_lvl = 1'b1;
				end
				r.pulse_left = c.pulse_ms;
			end else begin
				r.up_lvl = 1'b0;
				r.dn_lvl = 1'b0;
			end
			r.motion      = DIR_STOP;
			r.travel_left = '0;
		end
		return r;
	endfunction

	function automatic st_t start_motion(input st_t s, input logic [1:0] dir, input cfg_t c);
		st_t         r;
		logic [20:0] sum;
		r   = s;
		sum = {1'b0, s.imp_len} + {1'b0, c.pulse_ms};
		if (s.motion != DIR_STOP) begin
			r = halt_motion(s, c);
		end else begin
			r.up_lvl = (dir == DIR_UP);
			r.dn_lvl = (dir == DIR_DOWN);
			r.motion = dir;
			if (c.pulse_ms != '0)
				r.pulse_left = c.pulse_ms;
			if (s.imp_pending) begin
				if ({3'b000, sum} < c.travel_ms)
					r.stop_left = (sum == '0) ? 21'd1 : sum;
			end else begin
				r.cmd = {1'b0, dir};
			end
			if (s.rev_target == dir) begin
				r.rev_left   = '0;
				r.rev_target = DIR_STOP;
			end
			r.travel_left = (c.travel_ms == '0) ? 24'd1 : c.travel_ms;
		end
		return r;
	endfunction

	// A request against the current motion stops and schedules a reversal.
	function automatic st_t request_motion(input st_t s, input logic [1:0] dir, input cfg_t c);
		st_t r;
		r = s;
		if (s.motion != DIR_STOP) begin
			r = halt_motion(s, c);
			if (s.motion != dir) begin
				r.cmd        = {1'b0, dir};
				r.rev_left   = c.rev_ms;
				r.rev_target = dir;
			end
		end else begin
			r = start_motion(s, dir, c);
		end
		return r;
	endfunction

	function automatic st_t toggle_motion(input st_t s, input cfg_t c);
		st_t r;
		r = s;
		if (s.motion == DIR_UP) begin
			r.prev_dir = 1'b0;
			r = start_motion(r, DIR_DOWN, c);
		end else if (s.motion == DIR_DOWN) begin
			r.prev_dir = 1'b1;
			r = start_motion(r, DIR_UP, c);
		end else if (!s.prev_dir) begin
			r = start_motion(r, DIR_DOWN, c);
		end else begin
			r = start_motion(r, DIR_UP, c);
		end
		return r;
	endfunction

endpackage

FILE: rtl/rsrc_regs.sv
// Configuration register file with its APB-style access port.
module rsrc_regs import rsrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [13:0] travel_s_q;
	logic [19:0] pulse_q;
	logic        pair_stop_q;
	logic [23:0] travel_ms_q;
	logic [19:0] rev_ms_q;
	logic        wr_en;
	reg_idx_t    idx;
	logic [23:0] travel_ms_new;
	logic [20:0] rev_sum;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

	// Derived durations are worked out once, when the register is written.
	assign travel_ms_new = {10'd0, pwdata[13:0]} * 24'(MS_PER_S);
	assign rev_sum       = 21'(REV_GAP_MS) + {1'b0, pwdata[19:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_s_q  <= 14'd60;
			travel_ms_q <= 24'(60 * MS_PER_S);
			pulse_q     <= '0;
			rev_ms_q    <= 20'(REV_GAP_MS);
			pair_stop_q <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_TRAVEL: begin
					travel_s_q  <= pwdata[13:0];
					travel_ms_q <= travel_ms_new;
				end
				REG_PULSE: begin
					pulse_q  <= pwdata[19:0];
					rev_ms_q <= rev_sum[20] ? 20'hFFFFF : rev_sum[19:0];
				end
				REG_PAIR_STOP: begin
					pair_stop_q <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TRAVEL:    prdata = {18'd0, travel_s_q};
			REG_PULSE:     prdata = {12'd0, pulse_q};
			REG_PAIR_STOP: prdata = {31'd0, pair_stop_q};
			default:       prdata = '0;
		endcase
	end

	assign cfg = '{
		travel_ms: travel_ms_q,
		pulse_ms:  pulse_q,
		pair_stop: pair_stop_q,
		rev_ms:    rev_ms_q
	};

endmodule

FILE: rtl/roller_shutter_relay_controller.sv
// Top level of the roller shutter relay controller: word handling and controller state.
//
// Usage. Input words arrive on in_valid/in_ready with fields op and action_ms.
// An op of zero is a 1 ms tick; the other codes are commands (up, down, toggle,
// stop, impulse up or down for action_ms, set open, set closed). For every
// accepted input word exactly one result word leaves on out_valid/out_ready,
// carrying both relay levels, the direction of motion, the recorded position,
// the last command code and a flag that marks the end of a travel.
// Timing: the whole state update runs between the controller state register
// and the result register, so the result is presented in the cycle after
// acceptance and a new word can be accepted on every cycle while the
// receiver keeps taking results. The rate is set by that one combinational
// pass through the tick and command handlers.
// Stalls: the result register is the only buffer. While it holds a word that
// the receiver has not taken, in_ready is low; it rises again in the same
// cycle that out_ready takes the waiting word, so flow is never broken.
// Reset: arst_n clears the controller to stopped, open, no command yet, all
// timers idle, and loads the registers with a 60 s travel time, no pulse mode
// and single-relay stopping. The APB-style port takes register writes at
// 0x0 (travel time, s), 0x4 (pulse time, ms) and 0x8 (stop both relays).
module roller_shutter_relay_controller import rsrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input words
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [3:0]        op,
	input  logic [19:0]       action_ms,
	// result words
	output logic              out_valid,
	input  logic              out_ready,
	output logic              relay_up,
	output logic              relay_down,
	output logic [1:0]        direction,
	output logic              position_open,
	output logic [2:0]        last_command,
	output logic              travel_done
);

	cfg_t cfg;
	st_t  st_q;
	st_t  st_nxt;
	res_t res_q;
	res_t res_nxt;
	logic out_valid_q;
	logic accept;

	rsrc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The result register may be refilled in the cycle its word is taken.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Next controller state for the word on the input. On a tick all four
	// timers count down together and those that reach zero are serviced in
	// the order travel, pulse, stop, reversal. A timer that an earlier
	// handler has reloaded on the same tick is no longer zero and so does not
	// fire.
	always_comb begin
		st_t        s;
		logic       ft;
		logic       fp;
		logic       fs;
		logic       fr;
		logic       done;
		logic [2:0] keep;
		logic [1:0] dir;

		s    = st_q;
		ft   = 1'b0;
		fp   = 1'b0;
		fs   = 1'b0;
		fr   = 1'b0;
		done = 1'b0;
		keep = st_q.cmd;
		dir  = DIR_STOP;

		if (op_t'(op) == OP_TICK) begin
			if (s.travel_left != '0) begin
				s.travel_left = s.travel_left - 24'd1;
				ft = (s.travel_left == '0);
			end
			if (s.pulse_left != '0) begin
				s.pulse_left = s.pulse_left - 20'd1;
				fp = (s.pulse_left == '0);
			end
			if (s.stop_left != '0) begin
				s.stop_left = s.stop_left - 21'd1;
				fs = (s.stop_left == '0);
			end
			if (s.rev_left != '0) begin
				s.rev_left = s.rev_left - 20'd1;
				fr = (s.rev_left == '0);
			end

			// End of travel: record where the shutter now is, keep the command.
			if (ft) begin
				keep = s.cmd;
				if (s.motion == DIR_UP) begin
					s.prev_dir  = 1'b0;
					s.open_flag = 1'b1;
				end else if (s.motion == DIR_DOWN) begin
					s.prev_dir  = 1'b1;
					s.open_flag = 1'b0;
				end
				s     = halt_motion(s, cfg);
				s.cmd = keep;
				done  = 1'b1;
			end
			if (fp && s.pulse_left == '0) begin
				s.up_lvl = 1'b0;
				s.dn_lvl = 1'b0;
			end
			// The scheduled stop of an impulse action.
			if (fs && s.stop_left == '0)
				s = halt_motion(s, cfg);
			// Restart after a reversal gap.
			if (fr && s.rev_left == '0) begin
				dir          = s.rev_target;
				s.rev_target = DIR_STOP;
				if (dir == DIR_UP || dir == DIR_DOWN)
					s = start_motion(s, dir, cfg);
			end
		end else begin
			s.imp_pending = 1'b0;
			unique case (op_t'(op))
				OP_UP:     s = request_motion(s, DIR_UP, cfg);
				OP_DOWN:   s = request_motion(s, DIR_DOWN, cfg);
				OP_TOGGLE: s = toggle_motion(s, cfg);
				OP_STOP:   s = halt_motion(s, cfg);
				OP_IMP_UP: begin
					s.imp_pending = 1'b1;
					s.imp_len     = action_ms;
					s             = request_motion(s, DIR_UP, cfg);
					s.cmd         = CMD_IMP_UP;
				end
				OP_IMP_DOWN: begin
					s.imp_pending = 1'b1;
					s.imp_len     = action_ms;
					s             = request_motion(s, DIR_DOWN, cfg);
					s.cmd         = CMD_IMP_DOWN;
				end
				OP_SET_OPEN: begin
					s.open_flag = 1'b1;
					s.cmd       = {1'b0, DIR_UP};
				end
				OP_SET_CLOSED: begin
					s.open_flag = 1'b0;
					s.cmd       = {1'b0, DIR_DOWN};
				end
				default: begin
				end
			endcase
		end

		st_nxt  = s;
		res_nxt = '{
			relay_up:      s.up_lvl,
			relay_down:    s.dn_lvl,
			direction:     s.motion,
			position_open: s.open_flag,
			last_command:  s.cmd,
			travel_done:   done
		};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				st_q <= st_nxt;
			if (accept)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Result payload needs no reset; it is qualified by out_valid.
	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res_nxt;
	end

	assign out_valid     = out_valid_q;
	assign relay_up      = res_q.relay_up;
	assign relay_down    = res_q.relay_down;
	assign direction     = res_q.direction;
	assign position_open = res_q.position_open;
	assign last_command  = res_q.last_command;
	assign travel_done   = res_q.travel_done;

endmodule
